>>> rtl/fcr_pkg.sv
package fcr_pkg;

    // Width of the frame byte counter and the frame length register
    localparam int unsigned LengthBits = 24;

    localparam logic [7:0] MarkerFirst  = 8'hff;
    localparam logic [7:0] MarkerSecond = 8'hd9;
    localparam logic [LengthBits:0] TrailerBytes = (LengthBits + 1)'(4);

    localparam logic [LengthBits-1:0] FrameLengthReset = LengthBits'(2052);

    // One verdict, as it leaves the block
    typedef struct packed {
        logic                  checksum_ok;
        logic [31:0]           computed_sum;
        logic [31:0]           received_sum;
        logic [LengthBits-1:0] marker_end_length;
    } t_verdict;

endpackage

>>> rtl/fcr_frame.sv
module fcr_frame
    import fcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  logic [LengthBits-1:0] i_frame_length,
    output logic                  o_result_valid,
    output t_verdict              o_result
);

    logic [LengthBits-1:0] r_byte_index, n_byte_index;
    logic [31:0]           r_running_sum, n_running_sum;
    logic [31:0]           r_trailer_shift, n_trailer_shift;
    logic [7:0]            r_previous_byte, n_previous_byte;
    logic                  r_previous_valid, n_previous_valid;
    logic [LengthBits-1:0] r_marker_length, n_marker_length;

    logic [LengthBits:0]   idx_ext;
    logic [LengthBits:0]   count;
    logic [LengthBits:0]   flen_ext;
    logic                  is_payload;
    logic                  marker_hit;
    logic                  last_beat;
    logic [31:0]           sum_upd;
    logic [31:0]           trailer_upd;
    logic [LengthBits-1:0] marker_upd;

    // Per-beat update of the frame state
    always_comb begin
        idx_ext     = {1'b0, r_byte_index};
        flen_ext    = {1'b0, i_frame_length};
        count       = idx_ext + (LengthBits + 1)'(1);
        is_payload  = (idx_ext + TrailerBytes) < flen_ext;
        marker_hit  = r_previous_valid && (r_previous_byte == MarkerFirst)
                      && (i_rx_byte == MarkerSecond);
        last_beat   = count >= flen_ext;
        sum_upd     = is_payload ? (r_running_sum + {24'd0, i_rx_byte}) : r_running_sum;
        trailer_upd = {r_trailer_shift[23:0], i_rx_byte};
        marker_upd  = marker_hit ? count[LengthBits-1:0] : r_marker_length;
    end

    // Verdict for the closing beat of a frame
    always_comb begin
        o_result_valid             = i_accept && last_beat;
        o_result.checksum_ok       = (trailer_upd == sum_upd);
        o_result.computed_sum      = sum_upd;
        o_result.received_sum      = trailer_upd;
        o_result.marker_end_length = marker_upd;
    end

    // Next state: advance, or clear after the closing beat
    always_comb begin
        n_byte_index     = r_byte_index;
        n_running_sum    = r_running_sum;
        n_trailer_shift  = r_trailer_shift;
        n_previous_byte  = r_previous_byte;
        n_previous_valid = r_previous_valid;
        n_marker_length  = r_marker_length;
        if (i_accept) begin
            if (last_beat) begin
                n_byte_index     = '0;
                n_running_sum    = '0;
                n_trailer_shift  = '0;
                n_previous_byte  = '0;
                n_previous_valid = 1'b0;
                n_marker_length  = '0;
            end else begin
                n_byte_index     = count[LengthBits-1:0];
                n_running_sum    = sum_upd;
                n_trailer_shift  = trailer_upd;
                n_previous_byte  = i_rx_byte;
                n_previous_valid = 1'b1;
                n_marker_length  = marker_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index     <= '0;
            r_running_sum    <= '0;
            r_trailer_shift  <= '0;
            r_previous_byte  <= '0;
            r_previous_valid <= 1'b0;
            r_marker_length  <= '0;
        end else begin
            r_byte_index     <= n_byte_index;
            r_running_sum    <= n_running_sum;
            r_trailer_shift  <= n_trailer_shift;
            r_previous_byte  <= n_previous_byte;
            r_previous_valid <= n_previous_valid;
            r_marker_length  <= n_marker_length;
        end
    end

endmodule

>>> rtl/fcr_out_buf.sv
module fcr_out_buf
    import fcr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_verdict i_data,
    input  logic     i_stall,
    output logic     o_valid,
    output logic     o_full,
    output t_verdict o_data
);

    logic     r_out_valid, n_out_valid;
    logic     r_skid_valid, n_skid_valid;
    t_verdict r_out, n_out;
    t_verdict r_skid, n_skid;
    logic     take;

    // Output register with one skid entry behind it
    always_comb begin
        take         = r_out_valid && !i_stall;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_full  = r_skid_valid;
    assign o_data  = r_out;

endmodule

>>> rtl/frame_checksum_receiver_core.sv
// Frame checksum receiver: sums payload bytes of a frame and checks the sum
// against the four-byte big-endian trailer that closes the frame.
//
// Input channel (i_valid / o_stall / i_rx_byte): one byte per beat. A byte is
// taken on a rising edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall / verdict fields): one verdict beat for
// the last byte of every frame, taken on an edge with o_valid high and
// i_stall low. Other bytes give no beat.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_frame_length): sets the
// total frame length, trailer included. Always ready; write only when idle.
//
// Throughput: one byte per cycle while o_stall is low. The verdict is registered
// into the output register, or into the skid entry while that is held; the byte
// state update and the 32-bit sum and compare are combinational ahead of it.
// When the receiver stalls, one more verdict is held in a skid entry; once
// that is full, o_stall rises until the output register drains.
// Reset clears the frame state and output buffer, frame length becomes 2052.
module frame_checksum_receiver_core
    import fcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_checksum_ok,
    output logic [31:0]           o_computed_sum,
    output logic [31:0]           o_received_sum,
    output logic [LengthBits-1:0] o_marker_end_length,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [LengthBits-1:0] i_cfg_frame_length
);

    logic [LengthBits-1:0] r_frame_length;
    logic                  accept;
    logic                  result_valid;
    logic                  buf_full;
    t_verdict              result;
    t_verdict              out_data;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = buf_full;
    assign accept      = i_valid && !buf_full;

    // Frame length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= FrameLengthReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frame_length <= i_cfg_frame_length;
        end
    end

    fcr_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_rx_byte      (i_rx_byte),
        .i_frame_length (r_frame_length),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    fcr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result_valid),
        .i_data  (result),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_full  (buf_full),
        .o_data  (out_data)
    );

    assign o_checksum_ok       = out_data.checksum_ok;
    assign o_computed_sum      = out_data.computed_sum;
    assign o_received_sum      = out_data.received_sum;
    assign o_marker_end_length = out_data.marker_end_length;

endmodule

>>> verif/frame_checksum_receiver_core_tb.sv
`timescale 1ns / 1ps

module frame_checksum_receiver_core_tb;
    import fcr_pkg::*;

    localparam int unsigned HalfPeriod   = 6;
    localparam int unsigned ResetCycles  = 8;
    localparam int unsigned DrainCycles  = 4;
    localparam int unsigned HoldCycles   = 80;
    localparam int unsigned StallLimit   = 2000;
    localparam int unsigned RandomBytes  = 1000;
    localparam logic [LengthBits-1:0] LengthMax = '1;

    typedef enum logic {FEED_BYTE, SET_LENGTH} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [LengthBits-1:0] value;
        int                    reps;
        bit                    typed;
        t_verdict              want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_rx_byte = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_checksum_ok;
    logic [31:0]           o_computed_sum;
    logic [31:0]           o_received_sum;
    logic [LengthBits-1:0] o_marker_end_length;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [LengthBits-1:0] i_cfg_frame_length = '0;

    // Sideband that rides with each byte beat: a typed-in verdict for that byte
    bit       feed_typed = 1'b0;
    t_verdict feed_verdict = '0;

    // Checksum predictor state
    logic [LengthBits-1:0] frame_len = FrameLengthReset;
    logic [LengthBits-1:0] byte_count = '0;
    logic [31:0]           payload_sum = '0;
    logic [31:0]           trailer_bytes = '0;
    logic [7:0]            last_byte = '0;
    bit                    last_valid = 1'b0;
    logic [LengthBits-1:0] marker_count = '0;

    t_verdict verdict_q[$];
    t_row     stim_rows[$];

    int  mismatches = 0;
    int  bytes_sent = 0;
    int  quiet_cycles = 0;
    bit  sender_gaps = 1'b1;
    bit  receiver_gaps = 1'b1;
    bit  hold_req = 1'b0;

    frame_checksum_receiver_core DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_rx_byte           (i_rx_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_checksum_ok       (o_checksum_ok),
        .o_computed_sum      (o_computed_sum),
        .o_received_sum      (o_received_sum),
        .o_marker_end_length (o_marker_end_length),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_frame_length  (i_cfg_frame_length)
    );

    always begin
        i_clk = 1'b0;
        #HalfPeriod;
        i_clk = 1'b1;
        #HalfPeriod;
    end

    // Predict one byte: update frame state, return the verdict on the last byte
    task automatic take_byte(input logic [7:0] b, output bit done, output t_verdict v);
        logic [LengthBits:0]   count;
        logic [LengthBits+1:0] trailer_start;
        count = {1'b0, byte_count} + (LengthBits + 1)'(1);
        trailer_start = {2'b0, byte_count} + (LengthBits + 2)'(4);
        done = 1'b0;
        v = '0;
        if (trailer_start < {2'b0, frame_len})
            payload_sum = payload_sum + {24'b0, b};
        // FF D9 end-of-image; never ends on the first byte of a frame
        if (last_valid && last_byte == MarkerFirst && b == MarkerSecond)
            marker_count = count[LengthBits-1:0];
        trailer_bytes = {trailer_bytes[23:0], b};
        last_byte = b;
        last_valid = 1'b1;
        if (count >= {1'b0, frame_len}) begin
            v.checksum_ok = (trailer_bytes == payload_sum);
            v.computed_sum = payload_sum;
            v.received_sum = trailer_bytes;
            v.marker_end_length = marker_count;
            done = 1'b1;
            byte_count = '0;
            payload_sum = '0;
            trailer_bytes = '0;
            last_byte = '0;
            last_valid = 1'b0;
            marker_count = '0;
        end else begin
            byte_count = count[LengthBits-1:0];
        end
    endtask

    task automatic flag_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, seen);
        mismatches++;
    endtask

    // Track accepted beats on all channels and check verdicts
    always @(posedge i_clk) begin
        t_verdict v;
        t_verdict want;
        bit       done;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                frame_len = i_cfg_frame_length;
            if (i_valid && !o_stall) begin
                take_byte(i_rx_byte, done, v);
                if (done)
                    verdict_q.push_back(feed_typed ? feed_verdict : v);
            end
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: verdict with none pending: ok %b, computed %h, received %h",
                             $time, o_checksum_ok, o_computed_sum, o_received_sum);
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_checksum_ok !== want.checksum_ok)
                        flag_field("checksum_ok", 32'(want.checksum_ok),
                                   32'(o_checksum_ok));
                    if (o_computed_sum !== want.computed_sum)
                        flag_field("computed_sum", want.computed_sum, o_computed_sum);
                    if (o_received_sum !== want.received_sum)
                        flag_field("received_sum", want.received_sum, o_received_sum);
                    if (o_marker_end_length !== want.marker_end_length)
                        flag_field("marker_end_length", 32'(want.marker_end_length),
                                   32'(o_marker_end_length));
                end
            end
        end
    end

    // Watchdog: cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("frame_checksum_receiver_core_tb NOT OK");
            $finish;
        end
    end

    // Verdict receiver: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_stall <= receiver_gaps && ($urandom_range(0, 99) < 33);
            end
        end
    end

    // Offer one byte and wait for its beat
    task automatic feed_byte(input logic [7:0] b, input bit typed, input t_verdict want);
        if (sender_gaps && $urandom_range(0, 99) < 33) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        feed_typed <= typed;
        feed_verdict <= want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Let every pending verdict arrive, then let the pipeline settle
    task automatic drain_verdicts();
        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic set_frame_length(input logic [LengthBits-1:0] len);
        drain_verdicts();
        i_cfg_valid <= 1'b1;
        i_cfg_frame_length <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_bytes(input logic [7:0] b, input int reps);
        t_row r;
        r.kind = FEED_BYTE;
        r.value = b;
        r.reps = reps;
        r.typed = 1'b0;
        r.want = '0;
        stim_rows.push_back(r);
    endtask

    task automatic add_last_byte(input logic [7:0] b, input int reps, input logic ok,
                                 input logic [31:0] comp, input logic [31:0] recv,
                                 input logic [LengthBits-1:0] mark);
        t_row r;
        r.kind = FEED_BYTE;
        r.value = b;
        r.reps = reps;
        r.typed = 1'b1;
        r.want.checksum_ok = ok;
        r.want.computed_sum = comp;
        r.want.received_sum = recv;
        r.want.marker_end_length = mark;
        stim_rows.push_back(r);
    endtask

    task automatic add_length(input logic [LengthBits-1:0] len);
        t_row r;
        r.kind = SET_LENGTH;
        r.value = len;
        r.reps = 1;
        r.typed = 1'b0;
        r.want = '0;
        stim_rows.push_back(r);
    endtask

    // Bias toward marker bytes so FF D9 pairs show up often
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return MarkerFirst;
        if (r < 30) return MarkerSecond;
        if (r < 35) return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // One frame: mostly a correct trailer, sometimes corrupted or pure noise
    task automatic send_frame(input int len, input bit cut_short);
        int          span;
        int          stop;
        bit          good;
        logic [31:0] sum;
        logic [7:0]  b;
        span = (len == 0) ? 1 : len;
        stop = (cut_short && span > 1) ? $urandom_range(1, span - 1) : span;
        good = (span > 4) && ($urandom_range(0, 99) < 75);
        sum = '0;
        if (good && $urandom_range(0, 99) < 10)
            sum = 32'(1) << $urandom_range(0, 31);
        for (int i = 0; i < stop; i++) begin
            if (good && i >= span - 4) begin
                b = sum[8 * (span - 1 - i) +: 8];
            end else begin
                b = pick_byte();
                if (good) sum = sum + {24'b0, b};
            end
            feed_byte(b, 1'b0, '0);
        end
    endtask

    initial begin
        int start_count;
        int phase;
        int len;
        int frames;
        int r;

        // Directed rows; reset length first, no register write yet
        add_last_byte(8'hff, 2052, 1'b0, 32'd522240, 32'hffff_ffff, '0);
        add_length(8);
        add_bytes(8'hff, 1);
        add_bytes(8'hd9, 1);
        add_bytes(8'h00, 1);
        add_bytes(8'h01, 1);
        add_bytes(8'h00, 2);
        add_bytes(8'h01, 1);
        add_last_byte(8'hd9, 1, 1'b1, 32'h0000_01d9, 32'h0000_01d9, 24'd2);
        // Trailer-only frames; next frame opens with D9 right after an FF
        add_length(4);
        add_bytes(8'h00, 3);
        add_last_byte(8'hff, 1, 1'b0, 32'h0, 32'h0000_00ff, '0);
        add_bytes(8'hd9, 1);
        add_bytes(8'hff, 1);
        add_bytes(8'hd9, 1);
        add_last_byte(8'h00, 1, 1'b0, 32'h0, 32'hd9ff_d900, 24'd3);
        // Short frames and zero length
        add_length(2);
        add_bytes(8'hab, 1);
        add_last_byte(8'hcd, 1, 1'b0, 32'h0, 32'h0000_abcd, '0);
        add_length(1);
        add_last_byte(8'h00, 1, 1'b1, 32'h0, 32'h0, '0);
        add_length(0);
        add_last_byte(8'h80, 1, 1'b0, 32'h0, 32'h0000_0080, '0);
        // Max length, then cut down to the count of bytes already taken
        add_length(LengthMax);
        add_bytes(8'h01, 1);
        add_bytes(8'h02, 1);
        add_bytes(8'h03, 1);
        add_length(3);
        add_last_byte(8'h04, 1, 1'b0, 32'd6, 32'h0102_0304, '0);

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == SET_LENGTH) begin
                set_frame_length(stim_rows[k].value);
            end else begin
                for (int n = 0; n < stim_rows[k].reps; n++)
                    feed_byte(stim_rows[k].value[7:0],
                              stim_rows[k].typed && n == stim_rows[k].reps - 1,
                              stim_rows[k].want);
            end
        end

        start_count = bytes_sent;

        // Back-pressure: one verdict per byte while the receiver holds off
        sender_gaps = 1'b0;
        set_frame_length(1);
        hold_req = 1'b1;
        for (int n = 0; n < 40; n++)
            feed_byte(pick_byte(), 1'b0, '0);
        sender_gaps = 1'b1;

        phase = 0;
        while (bytes_sent - start_count < RandomBytes) begin
            // A few phases run flat out on both sides
            sender_gaps = !(phase >= 4 && phase <= 6);
            receiver_gaps = sender_gaps;
            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(5, 24);
            else if (r < 85) len = $urandom_range(1, 4);
            else if (r < 90) len = 0;
            else             len = $urandom_range(25, 120);
            set_frame_length(LengthBits'(len));
            frames = $urandom_range(2, 6);
            for (int f = 0; f < frames; f++)
                send_frame(len, f == frames - 1 && $urandom_range(0, 99) < 30);
            phase++;
        end

        drain_verdicts();
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0)
            $display("frame_checksum_receiver_core_tb OK");
        else
            $display("frame_checksum_receiver_core_tb NOT OK");
        $finish;
    end

endmodule
